// ===== rtl/mwc_random_subword_generator_defines.svh =====
// Assertion macros for the multiply-with-carry generator.
`ifndef MWC_RANDOM_SUBWORD_GENERATOR_DEFINES_SVH
`define MWC_RANDOM_SUBWORD_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define MWC_ASSERT_IMP(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("mwc generator check failed");

// Next-cycle implication, sampled on clock, off during reset
`define MWC_ASSERT_NXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("mwc generator check failed");

`endif

// ===== rtl/mwc_pkg.sv =====
package mwc_pkg;

   // Request kind codes
   localparam logic [2:0] KIND_WORD32 = 3'd0;
   localparam logic [2:0] KIND_WORD64 = 3'd1;
   localparam logic [2:0] KIND_HALF16 = 3'd2;
   localparam logic [2:0] KIND_BYTE8  = 3'd3;
   localparam logic [2:0] KIND_BIT1   = 3'd4;
   localparam logic [2:0] KIND_SEED   = 3'd5;

   // Generator constants
   localparam logic [15:0] MUL_Z  = 16'd36969;
   localparam logic [15:0] MUL_W  = 16'd18000;
   localparam logic [31:0] SEED_Z = 32'd362436069;
   localparam logic [31:0] SEED_W = 32'd521288629;

   // Countdown reload values: pieces per word minus one
   localparam logic       HALF_RELOAD = 1'b1;
   localparam logic [1:0] BYTE_RELOAD = 2'd3;
   localparam logic [4:0] BIT_RELOAD  = 5'd31;

   typedef struct packed {
      logic [31:0] z;
      logic [31:0] w;
      logic [31:0] word;
   } step_type;

   // One generator step: two 16x16 multiplies with carry-in add
   function automatic step_type mwc_step(input logic [31:0] z, input logic [31:0] w);
      step_type r;
      r.z    = (MUL_Z * z[15:0]) + {16'b0, z[31:16]};
      r.w    = (MUL_W * w[15:0]) + {16'b0, w[31:16]};
      r.word = {r.z[15:0], 16'b0} + r.w;
      return r;
   endfunction

endpackage

// ===== rtl/mwc_random_subword_generator.sv =====
// Multiply-with-carry random generator with sub-word delivery.
// Request channel (req_valid / req_stall): req_kind selects a 32-bit word,
// a 64-bit word, a 16-, 8- or 1-bit piece, or a seed load from req_seed_w
// and req_seed_z. Seed loads and unused kind codes give no result.
// Result channel (rsp_valid / rsp_stall): rsp_value, zero-extended to 64 bits.
// One generator step unit is shared; it runs one step per cycle.
// A 32-bit word or a piece that needs a fresh word takes one generator step
// in S_STEP after the accept beat; a 64-bit word takes two steps, the upper
// half first. A piece shifted out of a saved word and a seed load skip the
// step unit; such a piece waits in S_HOLD for the output register.
// The request side stalls while a request is in progress. A finished result
// sits in the output register; if the receiver stalls while another result
// is finished, that one is held internally and the request side stays stalled.
// Synchronous reset loads the default seed, clears all countdowns and drops
// any pending result.
module mwc_random_subword_generator
   import mwc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_seed_w,
   input  logic [31:0] req_seed_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value
);

`include "mwc_random_subword_generator_defines.svh"

   typedef enum logic [1:0] {S_IDLE, S_STEP, S_HOLD} state_type;

   state_type   state_ff, state_in;
   logic [2:0]  kind_ff, kind_in;
   logic        second_ff, second_in;
   logic [31:0] z_ff, z_in;
   logic [31:0] w_ff, w_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] saved_half_ff, saved_half_in;
   logic [31:0] saved_byte_ff, saved_byte_in;
   logic [31:0] saved_bit_ff, saved_bit_in;
   logic        left_half_ff, left_half_in;
   logic [1:0]  left_byte_ff, left_byte_in;
   logic [4:0]  left_bit_ff, left_bit_in;
   logic [63:0] result_ff, result_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   step_type    step;
   logic [63:0] step_result;
   logic        slot_free;

   assign step      = mwc_step(z_ff, w_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // Sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      second_in     = second_ff;
      z_in          = z_ff;
      w_in          = w_ff;
      hi_in         = hi_ff;
      saved_half_in = saved_half_ff;
      saved_byte_in = saved_byte_ff;
      saved_bit_in  = saved_bit_ff;
      left_half_in  = left_half_ff;
      left_byte_in  = left_byte_ff;
      left_bit_in   = left_bit_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      step_result   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               second_in = 1'b0;
               case (req_kind)
                  KIND_WORD32, KIND_WORD64: begin
                     state_in = S_STEP;
                  end
                  KIND_HALF16: begin
                     if (left_half_ff != 1'b0) begin
                        left_half_in  = 1'b0;
                        saved_half_in = saved_half_ff >> 16;
                        result_in     = {48'b0, saved_half_in[15:0]};
                        state_in      = S_HOLD;
                     end else begin
                        state_in = S_STEP;
                     end
                  end
                  KIND_BYTE8: begin
                     if (left_byte_ff != 2'd0) begin
                        left_byte_in  = left_byte_ff - 2'd1;
                        saved_byte_in = saved_byte_ff >> 8;
                        result_in     = {56'b0, saved_byte_in[7:0]};
                        state_in      = S_HOLD;
                     end else begin
                        state_in = S_STEP;
                     end
                  end
                  KIND_BIT1: begin
                     if (left_bit_ff != 5'd0) begin
                        left_bit_in  = left_bit_ff - 5'd1;
                        saved_bit_in = saved_bit_ff >> 1;
                        result_in    = {63'b0, saved_bit_in[0]};
                        state_in     = S_HOLD;
                     end else begin
                        state_in = S_STEP;
                     end
                  end
                  KIND_SEED: begin
                     z_in         = req_seed_z;
                     w_in         = req_seed_w;
                     left_half_in = 1'b0;
                     left_byte_in = 2'd0;
                     left_bit_in  = 5'd0;
                  end
                  default: ;
               endcase
            end
         end

         S_STEP: begin
            z_in = step.z;
            w_in = step.w;
            if (kind_ff == KIND_WORD64 && !second_ff) begin
               // first word of a 64-bit request is the upper half
               hi_in     = step.word;
               second_in = 1'b1;
            end else begin
               case (kind_ff)
                  KIND_WORD32: step_result = {32'b0, step.word};
                  KIND_WORD64: step_result = {hi_ff, step.word};
                  KIND_HALF16: begin
                     saved_half_in = step.word;
                     left_half_in  = HALF_RELOAD;
                     step_result   = {48'b0, step.word[15:0]};
                  end
                  KIND_BYTE8: begin
                     saved_byte_in = step.word;
                     left_byte_in  = BYTE_RELOAD;
                     step_result   = {56'b0, step.word[7:0]};
                  end
                  KIND_BIT1: begin
                     saved_bit_in = step.word;
                     left_bit_in  = BIT_RELOAD;
                     step_result  = {63'b0, step.word[0]};
                  end
                  default: step_result = '0;
               endcase
               // straight to the output register if it is free
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = step_result;
                  state_in     = S_IDLE;
               end else begin
                  result_in = step_result;
                  state_in  = S_HOLD;
               end
            end
         end

         S_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         second_ff     <= 1'b0;
         z_ff          <= SEED_Z;
         w_ff          <= SEED_W;
         saved_half_ff <= '0;
         saved_byte_ff <= '0;
         saved_bit_ff  <= '0;
         left_half_ff  <= 1'b0;
         left_byte_ff  <= 2'd0;
         left_bit_ff   <= 5'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         second_ff     <= second_in;
         z_ff          <= z_in;
         w_ff          <= w_in;
         saved_half_ff <= saved_half_in;
         saved_byte_ff <= saved_byte_in;
         saved_bit_ff  <= saved_bit_in;
         left_half_ff  <= left_half_in;
         left_byte_ff  <= left_byte_in;
         left_bit_ff   <= left_bit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      hi_ff        <= hi_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Checks
   `MWC_ASSERT_NXT(a_seed_clears, req_valid && !req_stall && req_kind == KIND_SEED, left_half_ff == 1'b0 && left_byte_ff == 2'd0 && left_bit_ff == 5'd0)
   `MWC_ASSERT_IMP(a_second_only_w64, state_ff == S_STEP && second_ff, kind_ff == KIND_WORD64)
   `MWC_ASSERT_NXT(a_idle_no_reload, rsp_valid_ff && !rsp_stall && state_ff == S_IDLE, !rsp_valid_ff)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
   import mwc_pkg::*;
();

   // Codes the block ignores
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;
   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 95;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [31:0] req_seed_w;
   logic [31:0] req_seed_z;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;

   // Predicted generator state
   logic [31:0] mwc_z;
   logic [31:0] mwc_w;
   logic [31:0] half_word;
   logic [31:0] byte_word;
   logic [31:0] bit_word;
   logic        half_left;
   logic [1:0]  byte_left;
   logic [4:0]  bit_left;

   logic [63:0] expected_values[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int seed_loads = 0;
   int ignored_codes = 0;
   int quiet_cycles = 0;

   mwc_random_subword_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_seed_w (req_seed_w),
      .req_seed_z (req_seed_z),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // One multiply-with-carry step on the predicted state
   function automatic logic [31:0] mwc_draw_word();
      mwc_z = 32'(MUL_Z) * 32'(mwc_z[15:0]) + 32'(mwc_z[31:16]);
      mwc_w = 32'(MUL_W) * 32'(mwc_w[15:0]) + 32'(mwc_w[31:16]);
      return {mwc_z[15:0], 16'b0} + mwc_w;
   endfunction

   // Expected value of one request; has_value is low for seed loads and spare codes
   function automatic logic [63:0] mwc_predict(input logic [2:0] kind,
                                               input logic [31:0] seed_w,
                                               input logic [31:0] seed_z,
                                               output logic has_value);
      logic [31:0] upper;
      logic [63:0] value;
      value = '0;
      has_value = 1'b1;
      case (kind)
         KIND_WORD32: begin
            value = {32'b0, mwc_draw_word()};
         end
         KIND_WORD64: begin
            upper = mwc_draw_word();
            value = {upper, mwc_draw_word()};
         end
         KIND_HALF16: begin
            if (half_left != 1'b0) begin
               half_left = 1'b0;
               half_word = half_word >> 16;
            end else begin
               half_left = HALF_RELOAD;
               half_word = mwc_draw_word();
            end
            value = {48'b0, half_word[15:0]};
         end
         KIND_BYTE8: begin
            if (byte_left != 2'd0) begin
               byte_left = byte_left - 2'd1;
               byte_word = byte_word >> 8;
            end else begin
               byte_left = BYTE_RELOAD;
               byte_word = mwc_draw_word();
            end
            value = {56'b0, byte_word[7:0]};
         end
         KIND_BIT1: begin
            if (bit_left != 5'd0) begin
               bit_left = bit_left - 5'd1;
               bit_word = bit_word >> 1;
            end else begin
               bit_left = BIT_RELOAD;
               bit_word = mwc_draw_word();
            end
            value = {63'b0, bit_word[0]};
         end
         KIND_SEED: begin
            mwc_w = seed_w;
            mwc_z = seed_z;
            half_left = 1'b0;
            byte_left = 2'd0;
            bit_left = 5'd0;
            has_value = 1'b0;
         end
         default: begin
            has_value = 1'b0;
         end
      endcase
      return value;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      if (error_count <= 10)
         $display("%0t mismatch (%s): expected %h, got %h", $time, what, want, got);
   endtask

   // Drive one request beat and update the prediction once it is taken
   task automatic send_request(input logic [2:0] kind, input logic [31:0] seed_w,
                               input logic [31:0] seed_z);
      logic        has_value;
      logic [63:0] value;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_seed_w <= seed_w;
      req_seed_z <= seed_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      value = mwc_predict(kind, seed_w, seed_z, has_value);
      if (has_value) expected_values.push_back(value);
      if (kind == KIND_SEED) seed_loads++;
      else if (kind == KIND_SPARE6 || kind == KIND_SPARE7) ignored_codes++;
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   // Extremes, every kind, countdown wrap, seed clearing countdowns, spare codes
   task automatic test_directed();
      send_request(KIND_WORD32, '0, '0);
      send_request(KIND_WORD64, '0, '0);
      repeat (3) send_request(KIND_HALF16, '0, '0);
      repeat (5) send_request(KIND_BYTE8, '0, '0);
      repeat (2) send_request(KIND_BIT1, '0, '0);
      // all-zero seed locks the generator at zero
      send_request(KIND_SEED, 32'h0000_0000, 32'h0000_0000);
      send_request(KIND_WORD32, '1, '1);
      send_request(KIND_SEED, 32'hffff_ffff, 32'hffff_ffff);
      send_request(KIND_WORD64, '0, '0);
      // half countdown was mid-word, the seed load forces a fresh draw
      send_request(KIND_HALF16, '0, '0);
      send_request(KIND_SPARE6, 32'hffff_ffff, 32'h0000_0000);
      send_request(KIND_SPARE7, 32'h0000_0000, 32'hffff_ffff);
      send_request(KIND_SEED, 32'haaaa_aaaa, 32'h5555_5555);
      send_request(KIND_BYTE8, '0, '0);
      send_request(KIND_BIT1, '0, '0);
   endtask

   // Bursts of one kind so the countdowns wrap; seeds and spare codes as noise
   task automatic test_random_traffic(input int item_count);
      int          sent;
      int          burst;
      int          pick;
      logic [2:0]  kind;
      logic [31:0] seed_w;
      logic [31:0] seed_z;
      sent = 0;
      while (sent < item_count) begin
         pick = $urandom_range(99);
         seed_w = $urandom;
         seed_z = $urandom;
         if (pick < 5) begin
            if ($urandom_range(9) == 0) seed_w = '0;
            else if ($urandom_range(9) == 0) seed_w = '1;
            if ($urandom_range(9) == 0) seed_z = '0;
            else if ($urandom_range(9) == 0) seed_z = '1;
            send_request(KIND_SEED, seed_w, seed_z);
            sent++;
         end else if (pick < 8) begin
            send_request(($urandom_range(1) != 0) ? KIND_SPARE6 : KIND_SPARE7,
                         seed_w, seed_z);
         end else begin
            kind = 3'($urandom_range(KIND_BIT1, KIND_WORD32));
            burst = (kind == KIND_BIT1) ? $urandom_range(70, 1) : $urandom_range(6, 1);
            repeat (burst) begin
               send_request(kind, $urandom, $urandom);
               sent++;
            end
         end
      end
   endtask

   // Sender holds off until every pending result is back
   task automatic test_drain_pause();
      test_random_traffic(20);
      wait_for_drain();
      test_random_traffic(20);
   endtask

   // Receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            report_mismatch("no result pending", 'x, rsp_value);
         end else begin
            want = expected_values.pop_front();
            results_checked++;
            if (rsp_value !== want) report_mismatch("value", want, rsp_value);
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", QUIET_LIMIT);
            $display("[mwc_random_subword_generator] ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_kind   = KIND_WORD32;
      req_seed_w = '0;
      req_seed_z = '0;
      mwc_z      = SEED_Z;
      mwc_w      = SEED_W;
      half_word  = '0;
      byte_word  = '0;
      bit_word   = '0;
      half_left  = 1'b0;
      byte_left  = 2'd0;
      bit_left   = 5'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_directed();
      test_random_traffic(PHASE_ITEMS);
      set_idling(75, 0);
      test_random_traffic(PHASE_ITEMS);
      set_idling(0, 75);
      test_random_traffic(PHASE_ITEMS);
      set_idling(8, 8);
      test_drain_pause();
      test_random_traffic(PHASE_ITEMS - 40);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_values.size() != 0)
         report_mismatch("results never arrived", 64'(expected_values.size()), 'x);

      $display("Checked %0d values from %0d requests (%0d seed loads, %0d spare codes),",
               results_checked, requests_sent, seed_loads, ignored_codes);
      $display("under sender gaps, receiver stalls, both at once and a full drain pause.");
      if (error_count == 0) begin
         $display("[mwc_random_subword_generator] OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[mwc_random_subword_generator] ERROR");
      end
      $finish;
   end

endmodule
